>>> rtl/column_field_edge_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// column field edge tracker assertion macros
// concurrent check wrappers; empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef COLUMN_FIELD_EDGE_TRACKER_UNIT_DEFINES_SVH
`define COLUMN_FIELD_EDGE_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CFET_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfet check failed");
`define CFET_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfet check failed");
`else
`define CFET_ASSERT_NOW(lbl, ante, cons)
`define CFET_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/cfet_pkg.sv
// ----------------------------------------------------------------------------
// cfet_pkg
// shared constants, codes and the reciprocal table of the column edge tracker
// ----------------------------------------------------------------------------
`default_nettype none

package cfet_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLUMNS - 1);

	localparam int ROW_W  = 12;
	localparam int EDGE_W = 13;
	localparam logic [EDGE_W-1:0] UNTOUCHED = 13'h1FFF;
	localparam logic [ROW_W-1:0]  ROW_MAX   = 12'hFFF;

	localparam int PER_W  = 7;
	localparam int REM_W  = 6;
	localparam int DIV_W  = 20;
	localparam int RCP_W  = 21;
	localparam int RCP_SH = 20;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FIELD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MINRUN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_QUERY  = 2'd3;

	localparam logic KIND_FINISH = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	localparam logic [1:0] STAT_ALL  = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_FILL = 2'd2;

	// floor(2^20 / p) up to p = 64, a period of zero acts as one and larger periods as 64
	function automatic logic [RCP_W-1:0] cfet_rcp(input logic [PER_W-1:0] p);
		case (p)
			7'd0:  cfet_rcp = 21'd1048576;
			7'd1:  cfet_rcp = 21'd1048576;
			7'd2:  cfet_rcp = 21'd524288;
			7'd3:  cfet_rcp = 21'd349525;
			7'd4:  cfet_rcp = 21'd262144;
			7'd5:  cfet_rcp = 21'd209715;
			7'd6:  cfet_rcp = 21'd174762;
			7'd7:  cfet_rcp = 21'd149796;
			7'd8:  cfet_rcp = 21'd131072;
			7'd9:  cfet_rcp = 21'd116508;
			7'd10: cfet_rcp = 21'd104857;
			7'd11: cfet_rcp = 21'd95325;
			7'd12: cfet_rcp = 21'd87381;
			7'd13: cfet_rcp = 21'd80659;
			7'd14: cfet_rcp = 21'd74898;
			7'd15: cfet_rcp = 21'd69905;
			7'd16: cfet_rcp = 21'd65536;
			7'd17: cfet_rcp = 21'd61680;
			7'd18: cfet_rcp = 21'd58254;
			7'd19: cfet_rcp = 21'd55188;
			7'd20: cfet_rcp = 21'd52428;
			7'd21: cfet_rcp = 21'd49932;
			7'd22: cfet_rcp = 21'd47662;
			7'd23: cfet_rcp = 21'd45590;
			7'd24: cfet_rcp = 21'd43690;
			7'd25: cfet_rcp = 21'd41943;
			7'd26: cfet_rcp = 21'd40329;
			7'd27: cfet_rcp = 21'd38836;
			7'd28: cfet_rcp = 21'd37449;
			7'd29: cfet_rcp = 21'd36157;
			7'd30: cfet_rcp = 21'd34952;
			7'd31: cfet_rcp = 21'd33825;
			7'd32: cfet_rcp = 21'd32768;
			7'd33: cfet_rcp = 21'd31775;
			7'd34: cfet_rcp = 21'd30840;
			7'd35: cfet_rcp = 21'd29959;
			7'd36: cfet_rcp = 21'd29127;
			7'd37: cfet_rcp = 21'd28339;
			7'd38: cfet_rcp = 21'd27594;
			7'd39: cfet_rcp = 21'd26886;
			7'd40: cfet_rcp = 21'd26214;
			7'd41: cfet_rcp = 21'd25575;
			7'd42: cfet_rcp = 21'd24966;
			7'd43: cfet_rcp = 21'd24385;
			7'd44: cfet_rcp = 21'd23831;
			7'd45: cfet_rcp = 21'd23301;
			7'd46: cfet_rcp = 21'd22795;
			7'd47: cfet_rcp = 21'd22310;
			7'd48: cfet_rcp = 21'd21845;
			7'd49: cfet_rcp = 21'd21399;
			7'd50: cfet_rcp = 21'd20971;
			7'd51: cfet_rcp = 21'd20560;
			7'd52: cfet_rcp = 21'd20164;
			7'd53: cfet_rcp = 21'd19784;
			7'd54: cfet_rcp = 21'd19418;
			7'd55: cfet_rcp = 21'd19065;
			7'd56: cfet_rcp = 21'd18724;
			7'd57: cfet_rcp = 21'd18396;
			7'd58: cfet_rcp = 21'd18078;
			7'd59: cfet_rcp = 21'd17772;
			7'd60: cfet_rcp = 21'd17476;
			7'd61: cfet_rcp = 21'd17189;
			7'd62: cfet_rcp = 21'd16912;
			7'd63: cfet_rcp = 21'd16644;
			default: cfet_rcp = 21'd16384;
		endcase
	endfunction

endpackage

`default_nettype wire

>>> rtl/column_field_edge_tracker_unit.sv
// ----------------------------------------------------------------------------
// column_field_edge_tracker_unit
// per-column field run tracking, frame finish fill and interpolated edge query
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream (tuser selects clear, sample, finish or
// query); finish and query each return one item on the m_ stream. Column
// state lives in two small synchronous RAMs (edge row and run length) with
// valid bits per column, so a clear only resets those bits. A sample has x
// split into column and remainder by a two-stage reciprocal divider; when it
// falls on a column, the run-length entry is then read, modified and written
// back. A query that hits a column exactly or lies at or past the last one
// takes no second division; one that interpolates sends the weighted sum
// through the divider a second time. A finish makes one pass over the valid
// bits to classify the frame and one pass writing filled entries. After any
// configuration write the column count is recomputed through the divider,
// which holds s_tready low while it runs; the same happens once after reset.
`default_nettype none

module column_field_edge_tracker_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [cfet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cfet_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// pixel_x [11:0], pixel_y [23:12], pixel_label [31:24]
	input  wire logic [31:0]                        s_tdata,
	// command [1:0]
	input  wire logic [1:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// edge_row [11:0], frame_status [13:12], zero [15:14]
	output logic [15:0]                             m_tdata,
	// result_kind [0]
	output logic [0:0]                              m_tuser
);
	import cfet_pkg::*;

	`include "column_field_edge_tracker_unit_defines.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_DIVD, S_SUPD, S_QMUL, S_QSUM, S_SCAN, S_FILL, S_RES
	} state_t;

	typedef enum logic [1:0] {
		JOB_NCOL, JOB_SAMPLE, JOB_QPOS, JOB_QINT
	} job_t;

	// configuration
	logic [7:0]        field_q, line_q, minr_q;
	logic [PER_W-1:0]  per_q;
	logic [11:0]       width_q;
	logic [12:0]       height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q  <= 8'd1;
			line_q   <= 8'd2;
			per_q    <= 7'd10;
			minr_q   <= 8'd5;
			width_q  <= 12'd320;
			height_q <= 13'd240;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIELD:  field_q  <= cfg_data[7:0];
				REG_LINE:   line_q   <= cfg_data[7:0];
				REG_PERIOD: per_q    <= cfg_data[PER_W-1:0];
				REG_MINRUN: minr_q   <= cfg_data[7:0];
				REG_WIDTH:  width_q  <= cfg_data[11:0];
				REG_HEIGHT: height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	logic [PER_W-1:0] p_eff;
	logic [RCP_W-1:0] rcp;
	assign p_eff = (per_q == '0) ? PER_W'(1) : per_q;
	assign rcp   = cfet_rcp(p_eff);

	// reciprocal divider pipeline
	logic [DIV_W-1:0]       dn_q;
	logic [DIV_W+RCP_W-1:0] prod_s1;
	logic [DIV_W-1:0]       dn_s1;
	logic [DIV_W-1:0]       qe_s2, qp_s2, dn_s2;
	logic [DIV_W+PER_W-1:0] qp_full;
	logic [DIV_W-1:0]       qe_w, rem, rem_fix, div_q;
	logic                   fix;
	logic [REM_W-1:0]       div_r;

	assign qe_w    = prod_s1[RCP_SH+DIV_W-1:RCP_SH];
	assign qp_full = (DIV_W+PER_W)'(qe_w) * (DIV_W+PER_W)'(p_eff);

	always_ff @(posedge clk) begin
		prod_s1 <= (DIV_W+RCP_W)'(dn_q) * (DIV_W+RCP_W)'(rcp);
		dn_s1   <= dn_q;
		qe_s2   <= qe_w;
		qp_s2   <= qp_full[DIV_W-1:0];
		dn_s2   <= dn_s1;
	end

	assign rem     = dn_s2 - qp_s2;
	assign fix     = rem >= DIV_W'(p_eff);
	assign rem_fix = fix ? rem - DIV_W'(p_eff) : rem;
	assign div_q   = qe_s2 + DIV_W'(fix);
	assign div_r   = rem_fix[REM_W-1:0];

	// control state
	state_t              state_q;
	job_t                job_q;
	logic                dwait_q;
	logic                dirty_q;
	logic [COL_W-1:0]    lastc_q;
	logic [COL_W-1:0]    col_q, scan_q;
	logic [ROW_W-1:0]    y_q;
	logic [7:0]          label_q;
	logic [REM_W-1:0]    r_q;
	logic                single_q, v0_q, v1_q;
	logic                seen_q, unseen_q;
	logic [DIV_W-1:0]    pa_q, pb_q;
	logic                res_kind_q;
	logic [ROW_W-1:0]    res_row_q;
	logic [1:0]          res_stat_q;
	logic [MAX_COLUMNS-1:0] vld_q, rvld_q;

	// memories
	logic [ROW_W-1:0] edge_mem [MAX_COLUMNS];
	logic [7:0]       run_mem [MAX_COLUMNS];
	logic [ROW_W-1:0] edge_rd0, edge_rd1;
	logic [7:0]       run_rd;
	logic             edge_we, run_we;
	logic [COL_W-1:0] edge_wa, ra0, ra1;
	logic [ROW_W-1:0] edge_wd;
	logic [7:0]       run_old, run_new;
	logic [ROW_W-1:0] fill;
	logic [12:0]      h1;
	logic             is_line, is_field;

	assign ra0 = (div_q >= DIV_W'(lastc_q)) ? lastc_q : div_q[COL_W-1:0];
	assign ra1 = ra0 + COL_W'(1);

	always_ff @(posedge clk) begin
		if (edge_we)
			edge_mem[edge_wa] <= edge_wd;
		edge_rd0 <= edge_mem[ra0];
		edge_rd1 <= edge_mem[ra1];
	end

	always_ff @(posedge clk) begin
		if (run_we)
			run_mem[col_q] <= run_new;
		run_rd <= run_mem[div_q[COL_W-1:0]];
	end

	assign is_line  = label_q == line_q;
	assign is_field = !is_line && (label_q == field_q);
	assign run_old  = rvld_q[col_q] ? run_rd : 8'd0;
	assign run_new  = (run_old == 8'hFF) ? run_old : run_old + 8'd1;
	assign h1       = height_q - 13'd1;
	assign fill     = (height_q == '0) ? '0 : ((h1 > 13'(ROW_MAX)) ? ROW_MAX : h1[ROW_W-1:0]);

	always_comb begin
		edge_we = 1'b0;
		edge_wa = col_q;
		edge_wd = y_q;
		run_we  = 1'b0;
		case (state_q)
			S_SUPD: begin
				if (is_field) begin
					run_we  = 1'b1;
					edge_we = run_new >= minr_q;
				end
			end
			S_FILL: begin
				edge_wa = scan_q;
				if (!seen_q) begin
					edge_we = 1'b1;
					edge_wd = fill;
				end else if (!vld_q[scan_q]) begin
					edge_we = 1'b1;
					edge_wd = '0;
				end
			end
			default: ;
		endcase
	end

	// query operands, untouched columns take part as the marker
	logic [EDGE_W-1:0] qa, qb;
	logic [PER_W-1:0]  pmr;
	assign qa  = v0_q ? EDGE_W'(edge_rd0) : UNTOUCHED;
	assign qb  = v1_q ? EDGE_W'(edge_rd1) : UNTOUCHED;
	assign pmr = p_eff - PER_W'(r_q);

	assign s_tready = (state_q == S_IDLE) && !dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			job_q      <= JOB_NCOL;
			dwait_q    <= 1'b0;
			dirty_q    <= 1'b1;
			lastc_q    <= '0;
			col_q      <= '0;
			scan_q     <= '0;
			y_q        <= '0;
			label_q    <= '0;
			r_q        <= '0;
			single_q   <= 1'b0;
			v0_q       <= 1'b0;
			v1_q       <= 1'b0;
			seen_q     <= 1'b0;
			unseen_q   <= 1'b0;
			pa_q       <= '0;
			pb_q       <= '0;
			dn_q       <= '0;
			res_kind_q <= KIND_FINISH;
			res_row_q  <= '0;
			res_stat_q <= STAT_ALL;
			vld_q      <= '0;
			rvld_q     <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			m_tuser    <= '0;
		end else begin
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (dirty_q) begin
						dn_q    <= DIV_W'(width_q);
						job_q   <= JOB_NCOL;
						dwait_q <= 1'b0;
						dirty_q <= 1'b0;
						state_q <= S_DIV;
					end else if (s_tvalid) begin
						y_q     <= s_tdata[23:12];
						label_q <= s_tdata[31:24];
						dn_q    <= DIV_W'(s_tdata[11:0]);
						dwait_q <= 1'b0;
						case (s_tuser)
							CMD_CLEAR: begin
								vld_q  <= '0;
								rvld_q <= '0;
							end
							CMD_SAMPLE: begin
								job_q   <= JOB_SAMPLE;
								state_q <= S_DIV;
							end
							CMD_FINISH: begin
								scan_q   <= '0;
								seen_q   <= 1'b0;
								unseen_q <= 1'b0;
								state_q  <= S_SCAN;
							end
							CMD_QUERY: begin
								job_q   <= JOB_QPOS;
								state_q <= S_DIV;
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (dwait_q)
						state_q <= S_DIVD;
					else
						dwait_q <= 1'b1;
				end
				S_DIVD: begin
					case (job_q)
						JOB_NCOL: begin
							lastc_q <= (div_q > DIV_W'(LAST_COL)) ? LAST_COL
								: div_q[COL_W-1:0];
							state_q <= S_IDLE;
						end
						JOB_SAMPLE: begin
							col_q <= div_q[COL_W-1:0];
							if (div_r != '0 || div_q > DIV_W'(lastc_q))
								state_q <= S_IDLE;
							else
								state_q <= S_SUPD;
						end
						JOB_QPOS: begin
							r_q      <= div_r;
							single_q <= (div_q >= DIV_W'(lastc_q)) || (div_r == '0);
							v0_q     <= vld_q[ra0];
							v1_q     <= vld_q[ra1];
							state_q  <= S_QMUL;
						end
						JOB_QINT: begin
							res_kind_q <= KIND_QUERY;
							res_stat_q <= STAT_ALL;
							res_row_q  <= (div_q > DIV_W'(ROW_MAX)) ? ROW_MAX
								: div_q[ROW_W-1:0];
							state_q    <= S_RES;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_SUPD: begin
					if (is_field) begin
						rvld_q[col_q] <= 1'b1;
						if (run_new >= minr_q)
							vld_q[col_q] <= 1'b1;
					end else if (!is_line) begin
						rvld_q[col_q] <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				S_QMUL: begin
					if (single_q) begin
						res_kind_q <= KIND_QUERY;
						res_stat_q <= STAT_ALL;
						res_row_q  <= (qa > EDGE_W'(ROW_MAX)) ? ROW_MAX : qa[ROW_W-1:0];
						state_q    <= S_RES;
					end else begin
						pa_q    <= DIV_W'(qa) * DIV_W'(pmr);
						pb_q    <= DIV_W'(qb) * DIV_W'(r_q);
						state_q <= S_QSUM;
					end
				end
				S_QSUM: begin
					dn_q    <= pa_q + pb_q;
					job_q   <= JOB_QINT;
					dwait_q <= 1'b0;
					state_q <= S_DIV;
				end
				S_SCAN: begin
					seen_q   <= seen_q | vld_q[scan_q];
					unseen_q <= unseen_q | !vld_q[scan_q];
					if (scan_q == lastc_q) begin
						scan_q  <= '0;
						state_q <= S_FILL;
					end else begin
						scan_q <= scan_q + COL_W'(1);
					end
				end
				S_FILL: begin
					if (!seen_q || !vld_q[scan_q])
						vld_q[scan_q] <= 1'b1;
					if (scan_q == lastc_q) begin
						res_kind_q <= KIND_FINISH;
						res_row_q  <= '0;
						res_stat_q <= !seen_q ? STAT_NONE : (unseen_q ? STAT_FILL : STAT_ALL);
						state_q    <= S_RES;
					end else begin
						scan_q <= scan_q + COL_W'(1);
					end
				end
				S_RES: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {2'b00, res_stat_q, res_row_q};
						m_tuser  <= res_kind_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we)
				dirty_q <= 1'b1;
		end
	end

	// checks
	`CFET_ASSERT_NOW(a_out_from_res, $rose(m_tvalid), $past(state_q == S_RES))
	`CFET_ASSERT_NOW(a_edge_wr_range, edge_we, edge_wa <= lastc_q)
	`CFET_ASSERT_NOW(a_supd_range, state_q == S_SUPD, col_q <= lastc_q)
	`CFET_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready && s_tuser != CMD_CLEAR,
		state_q != S_IDLE)

endmodule

`default_nettype wire

>>> tb/sv/column_field_edge_tracker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_field_edge_tracker_unit_test
// self-checking bench: labelled pixel frames go in through the input stream
// with random bursts and gaps. A behavioral copy of the column tracker
// predicts every finish status and edge query answer. Each output item is
// compared field by field while the output side stalls on its own pattern.
// The bench runs through several register settings, extremes among them.
// ----------------------------------------------------------------------------
module column_field_edge_tracker_unit_test;
	import cfet_pkg::*;

	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 1600;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  label;
	} pixel_item_t;

	typedef struct packed {
		logic        kind;
		logic [11:0] row;
		logic [1:0]  status;
	} edge_answer_t;

	typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_TOGGLE} ready_mode_e;
	typedef enum logic [1:0] {COL_FIELD, COL_MIXED, COL_BARE} col_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata   = '0;
	logic [1:0]            s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;
	logic [0:0]            m_tuser;

	column_field_edge_tracker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// register copies
	logic [7:0]  lbl_field;
	logic [7:0]  lbl_line;
	logic [6:0]  col_period;
	logic [7:0]  run_needed;
	logic [11:0] img_width;
	logic [12:0] img_height;

	// column state copies
	logic [12:0] edge_tab [MAX_COLUMNS];
	logic [7:0]  run_tab  [MAX_COLUMNS];

	pixel_item_t  pending_items [$];
	edge_answer_t expected_answers [$];
	pixel_item_t  offered;
	edge_answer_t want;

	int items_queued   = 0;
	int items_accepted = 0;
	int n_errors       = 0;
	int n_finish_seen  = 0;
	int n_query_seen   = 0;
	int n_settings     = 0;
	int burst_left     = 0;
	int gap_left       = 0;
	int pattern_left   = 0;
	int hold_count     = 0;
	int idle_cycles    = 0;
	bit pressure_armed = 1'b0;
	bit pressure_done  = 1'b0;
	ready_mode_e ready_mode = READY_ALWAYS;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned col_step();
		return (col_period == 0) ? 1 : col_period;
	endfunction

	function automatic int unsigned col_total();
		int unsigned n;
		n = img_width / col_step() + 1;
		return (n > MAX_COLUMNS) ? MAX_COLUMNS : n;
	endfunction

	function automatic void wipe_columns();
		int i;
		for (i = 0; i < MAX_COLUMNS; i++) begin
			edge_tab[i] = UNTOUCHED;
			run_tab[i]  = 8'd0;
		end
	endfunction

	// advance the column state by one item and queue any answer it produces
	function automatic void track_item(input pixel_item_t it);
		int unsigned p, n, c, r, v, fill;
		int i;
		bit seen, unseen;
		edge_answer_t ans;
		p = col_step();
		n = col_total();
		c = it.x / p;
		r = it.x % p;
		ans = '0;
		case (it.cmd)
			CMD_CLEAR: wipe_columns();
			CMD_SAMPLE: begin
				if (r == 0 && c < n && it.label != lbl_line) begin
					if (it.label == lbl_field) begin
						if (run_tab[c] != 8'hFF)
							run_tab[c] = run_tab[c] + 8'd1;
						if (run_tab[c] >= run_needed)
							edge_tab[c] = {1'b0, it.y};
					end else begin
						run_tab[c] = 8'd0;
					end
				end
			end
			CMD_FINISH: begin
				seen = 1'b0;
				unseen = 1'b0;
				for (i = 0; i < n; i++) begin
					if (edge_tab[i] == UNTOUCHED)
						unseen = 1'b1;
					else
						seen = 1'b1;
				end
				if (!seen) begin
					fill = (img_height == 0) ? 0 : img_height - 1;
					if (fill > ROW_MAX)
						fill = ROW_MAX;
					for (i = 0; i < n; i++)
						edge_tab[i] = 13'(fill);
					ans.status = STAT_NONE;
				end else if (unseen) begin
					for (i = 0; i < n; i++)
						if (edge_tab[i] == UNTOUCHED)
							edge_tab[i] = 13'd0;
					ans.status = STAT_FILL;
				end else begin
					ans.status = STAT_ALL;
				end
				ans.kind = KIND_FINISH;
				expected_answers.push_back(ans);
			end
			default: begin
				if (c >= n - 1)
					v = edge_tab[n - 1];
				else if (r == 0)
					v = edge_tab[c];
				else
					v = (edge_tab[c] * (p - r) + edge_tab[c + 1] * r) / p;
				if (v > ROW_MAX)
					v = ROW_MAX;
				ans.kind = KIND_QUERY;
				ans.row = 12'(v);
				expected_answers.push_back(ans);
			end
		endcase
	endfunction

	function automatic int unsigned pick_label(input col_mode_e m);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (m)
			COL_FIELD: begin
				if (roll < 85)
					return lbl_field;
				else if (roll < 95)
					return lbl_line;
				return $urandom_range(0, 255);
			end
			COL_MIXED: begin
				if (roll < 40)
					return lbl_field;
				else if (roll < 70)
					return lbl_line;
				return $urandom_range(0, 255);
			end
			default: begin
				if (roll < 30)
					return lbl_line;
				roll = $urandom_range(0, 255);
				return (roll == lbl_field) ? lbl_line : roll;
			end
		endcase
	endfunction

	task automatic queue_item(input logic [1:0] cmd, input int unsigned x,
			input int unsigned y, input int unsigned label);
		pixel_item_t it;
		it.cmd   = cmd;
		it.x     = x[11:0];
		it.y     = y[11:0];
		it.label = label[7:0];
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		case (idx)
			REG_FIELD:  lbl_field  = 8'(val);
			REG_LINE:   lbl_line   = 8'(val);
			REG_PERIOD: col_period = 7'(val);
			REG_MINRUN: run_needed = 8'(val);
			REG_WIDTH:  img_width  = 12'(val);
			default:    img_height = 13'(val);
		endcase
	endtask

	task automatic apply_setting(input int unsigned f, input int unsigned l,
			input int unsigned per, input int unsigned mr, input int unsigned w,
			input int unsigned h);
		write_reg(REG_FIELD, f);
		write_reg(REG_LINE, l);
		write_reg(REG_PERIOD, per);
		write_reg(REG_MINRUN, mr);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic wait_idle();
		while (items_accepted != items_queued || expected_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one frame in row order with per-column label habits, then mostly a finish, and queries
	task automatic add_frame(input int rows);
		int unsigned p, n, y0, x;
		int c, r, k, roll;
		bit blank;
		col_mode_e modes [MAX_COLUMNS];
		p = col_step();
		n = col_total();
		blank = ($urandom_range(0, 6) == 0);
		for (c = 0; c < n; c++)
			modes[c] = blank ? COL_BARE : col_mode_e'($urandom_range(0, 2));
		if ($urandom_range(0, 9) != 0)
			queue_item(CMD_CLEAR, $urandom, $urandom, $urandom);
		y0 = $urandom_range(0, 4096 - rows);
		for (r = 0; r < rows; r++) begin
			for (c = 0; c < n; c++) begin
				if ($urandom_range(0, 9) != 0)
					queue_item(CMD_SAMPLE, c * p, y0 + r, pick_label(modes[c]));
				if ($urandom_range(0, 19) == 0) begin
					x = (p > 1) ? c * p + $urandom_range(1, p - 1) : n * p + $urandom_range(0, 7);
					queue_item(CMD_SAMPLE, x, y0 + r, pick_label(COL_FIELD));
				end
				if ($urandom_range(0, 49) == 0)
					queue_item(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
			end
		end
		if ($urandom_range(0, 9) != 0)
			queue_item(CMD_FINISH, $urandom, $urandom, $urandom);
		k = $urandom_range(2, 6);
		repeat (k) begin
			roll = $urandom_range(0, 3);
			if (roll < 2)
				x = $urandom_range(0, n * p);
			else if (roll == 2)
				x = $urandom_range(0, n - 1) * p;
			else
				x = $urandom_range(0, 4095);
			queue_item(CMD_QUERY, x, $urandom, $urandom);
		end
	endtask

	// input side: bursts and gaps, prediction on every accepted item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				track_item(offered);
				items_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left == 0 && burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					offered = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered.label, offered.y, offered.x};
					s_tuser <= offered.cmd;
					burst_left--;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: compare against the oldest answer, stall on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (m_tuser[0] == KIND_FINISH)
					n_finish_seen++;
				else
					n_query_seen++;
				if (expected_answers.size() == 0) begin
					$error("result item with nothing expected: kind %0d row %0d status %0d",
						m_tuser[0], m_tdata[11:0], m_tdata[13:12]);
					n_errors++;
				end else begin
					want = expected_answers.pop_front();
					if (m_tuser[0] !== want.kind) begin
						$error("result_kind mismatch: expected %0d, got %0d", want.kind, m_tuser[0]);
						n_errors++;
					end
					if (m_tdata[11:0] !== want.row) begin
						$error("edge_row mismatch: expected %0d, got %0d", want.row, m_tdata[11:0]);
						n_errors++;
					end
					if (m_tdata[13:12] !== want.status) begin
						$error("frame_status mismatch: expected %0d, got %0d",
							want.status, m_tdata[13:12]);
						n_errors++;
					end
				end
			end
			if (pressure_armed && !pressure_done) begin
				// long hold-off so the block backs up into its input
				m_tready <= 1'b0;
				hold_count++;
				if (hold_count >= HOLD_CYCLES)
					pressure_done = 1'b1;
			end else begin
				if (pattern_left == 0) begin
					ready_mode = ready_mode_e'($urandom_range(0, 3));
					pattern_left = $urandom_range(16, 96);
				end
				pattern_left--;
				case (ready_mode)
					READY_ALWAYS: m_tready <= 1'b1;
					READY_COIN:   m_tready <= $urandom_range(0, 1);
					READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:      m_tready <= pattern_left[1];
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int phase;
		int directed_count;
		int k;
		int unsigned p, w, f, l, mr, h;
		lbl_field  = 8'd1;
		lbl_line   = 8'd2;
		col_period = 7'd10;
		run_needed = 8'd5;
		img_width  = 12'd320;
		img_height = 13'd240;
		wipe_columns();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// state straight out of reset
		queue_item(CMD_QUERY, 0, 0, 0);
		queue_item(CMD_FINISH, 0, 0, 0);
		queue_item(CMD_QUERY, 15, 0, 0);
		wait_idle();

		// four columns, fill row saturates at the top
		apply_setting(1, 2, 4, 2, 12, 4096);
		queue_item(CMD_CLEAR, 0, 0, 0);
		queue_item(CMD_QUERY, 0, 0, 0);
		queue_item(CMD_FINISH, 0, 0, 0);
		queue_item(CMD_QUERY, 4095, 4095, 255);
		queue_item(CMD_CLEAR, 4095, 4095, 255);
		queue_item(CMD_SAMPLE, 0, 0, 1);
		queue_item(CMD_SAMPLE, 0, 1, 2);
		queue_item(CMD_SAMPLE, 0, 2, 1);
		queue_item(CMD_SAMPLE, 4, 2, 255);
		queue_item(CMD_SAMPLE, 8, 3, 1);
		queue_item(CMD_SAMPLE, 8, 4, 1);
		queue_item(CMD_SAMPLE, 3, 5, 1);
		queue_item(CMD_SAMPLE, 16, 5, 1);
		queue_item(CMD_SAMPLE, 4095, 4095, 0);
		queue_item(CMD_FINISH, 0, 0, 0);
		queue_item(CMD_QUERY, 2, 0, 0);
		queue_item(CMD_QUERY, 9, 0, 0);
		queue_item(CMD_QUERY, 12, 0, 0);
		wait_idle();
		directed_count = items_queued;

		phase = 0;
		while (items_queued - directed_count < RANDOM_ITEMS) begin
			case (phase)
				0: apply_setting(0, 255, 1, 1, 7, 1);
				1: apply_setting(3, 3, 0, 2, 5, 4096);
				2: apply_setting(255, 0, 1, 1, 4095, 4095);
				3: apply_setting(200, 201, 64, 255, 63, 2048);
				default: begin
					p = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 64);
					w = ((p == 0) ? 1 : p) * $urandom_range(0, 7)
						+ $urandom_range(0, ((p == 0) ? 1 : p) - 1);
					if (w == 0)
						w = 1;
					f = $urandom_range(0, 255);
					l = ($urandom_range(0, 9) == 0) ? f : $urandom_range(0, 255);
					mr = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
					h = $urandom_range(1, 4096);
					apply_setting(f, l, p, mr, w, h);
				end
			endcase
			if (phase == 4)
				pressure_armed = 1'b1;
			if (phase == 3) begin
				// one column, run counter driven past saturation
				queue_item(CMD_CLEAR, 0, 0, 0);
				for (k = 0; k < 270; k++)
					queue_item(CMD_SAMPLE, 0, 100 + k, (k % 37 == 36) ? lbl_line : lbl_field);
				queue_item(CMD_FINISH, 0, 0, 0);
				queue_item(CMD_QUERY, 0, 0, 0);
				queue_item(CMD_QUERY, 4095, 0, 0);
				queue_item(CMD_SAMPLE, 0, 500, 0);
				for (k = 0; k < 3; k++)
					queue_item(CMD_SAMPLE, 0, 501 + k, lbl_field);
				queue_item(CMD_QUERY, 30, 0, 0);
			end else if (phase == 2) begin
				repeat (2) add_frame(2);
			end else begin
				repeat ($urandom_range(3, 5)) add_frame($urandom_range(2, 8));
			end
			wait_idle();
			phase++;
		end

		if (expected_answers.size() != 0) begin
			$error("%0d expected answers never arrived", expected_answers.size());
			n_errors++;
		end
		$display("covered %0d items over %0d register settings", items_accepted, n_settings);
		$display("checked %0d frame finishes and %0d edge queries", n_finish_seen, n_query_seen);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/cfet_pkg.sv
rtl/column_field_edge_tracker_unit.sv
tb/sv/column_field_edge_tracker_unit_test.sv
